// ===== rtl/core/bsm_pkg.sv =====
package bsm_pkg;

  localparam int BITMAP_BITS_DEF = 256;
  localparam int WORD_BITS_DEF   = 64;

  localparam int OPCODE_W = 3;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;
  localparam int CFG_W    = 9;

  localparam logic [CFG_W-1:0] BITS_IN_USE_RST = CFG_W'(256);

  localparam logic [OPCODE_W-1:0] OP_TEST_SET       = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_TEST_CLR       = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_LAST_SET_CLR   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_LAST_ZERO_SET  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_FIRST_SET_CLR  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_FIRST_ZERO_SET = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DENIED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NODATA = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_POST
  } state_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic scan_next;
    logic finish;
    logic out_load_eval;
    logic out_load_post;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic item_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/bsm_ram.sv =====
module bsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bsm_ctrl.sv =====
module bsm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bsm_pkg::dp_stat_t    stat,
  output bsm_pkg::ctrl_cmd_t   cmd
);

  bsm_pkg::state_t state_r;
  bsm_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsm_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsm_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_nxt = bsm_pkg::ST_IDLE;
      end
      bsm_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = bsm_pkg::ST_EVAL;
      end
      bsm_pkg::ST_EVAL: begin
        if (stat.item_done) begin
          state_nxt = stat.out_free ? bsm_pkg::ST_IDLE : bsm_pkg::ST_POST;
        end
      end
      bsm_pkg::ST_POST: begin
        if (stat.out_free) state_nxt = bsm_pkg::ST_IDLE;
      end
      default: state_nxt = bsm_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      bsm_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      bsm_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      bsm_pkg::ST_EVAL: begin
        cmd.scan_next     = !stat.item_done;
        cmd.finish        = stat.item_done;
        cmd.out_load_eval = stat.item_done && stat.out_free;
      end
      bsm_pkg::ST_POST: begin
        cmd.out_load_post = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/bsm_dp.sv =====
module bsm_dp #(
  parameter int BITMAP_BITS = bsm_pkg::BITMAP_BITS_DEF,
  parameter int WORD_BITS   = bsm_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bsm_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic [bsm_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [bsm_pkg::INDEX_W-1:0]   in_bit_index,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [bsm_pkg::STATUS_W-1:0]  out_status,
  output logic [bsm_pkg::POS_W-1:0]     out_position,
  input  bsm_pkg::ctrl_cmd_t            cmd,
  output bsm_pkg::dp_stat_t             stat
);

  localparam int NWORDS    = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int OW        = $clog2(WORD_BITS);
  localparam int CW_A      = $clog2(BITMAP_BITS + WORD_BITS + 1);
  localparam int CW        = (CW_A > bsm_pkg::CFG_W) ? CW_A : bsm_pkg::CFG_W + 1;
  localparam int IDX_SPAN  = 1 << bsm_pkg::INDEX_W;
  localparam int IDX_WRDS  = (IDX_SPAN + WORD_BITS - 1) / WORD_BITS;
  localparam int DEC_WORDS = (IDX_WRDS < NWORDS) ? IDX_WRDS : NWORDS;
  localparam int TOP_BASE  = (NWORDS - 1) * WORD_BITS;

  function automatic logic op_test(input logic [bsm_pkg::OPCODE_W-1:0] op);
    return op == bsm_pkg::OP_TEST_SET || op == bsm_pkg::OP_TEST_CLR;
  endfunction

  function automatic logic op_top(input logic [bsm_pkg::OPCODE_W-1:0] op);
    return op == bsm_pkg::OP_LAST_SET_CLR || op == bsm_pkg::OP_LAST_ZERO_SET;
  endfunction

  logic [bsm_pkg::CFG_W-1:0]    bits_in_use_r, bits_in_use_nxt;
  logic [bsm_pkg::OPCODE_W-1:0] op_r, op_nxt;
  logic [OW-1:0]                off_r, off_nxt;
  logic [AW-1:0]                addr_r, addr_nxt;
  logic [CW-1:0]                base_r, base_nxt;
  logic [AW-1:0]                clr_cnt_r, clr_cnt_nxt;
  logic [bsm_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [bsm_pkg::POS_W-1:0]    res_pos_r, res_pos_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [bsm_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [bsm_pkg::POS_W-1:0]    out_position_r, out_position_nxt;

  logic [bsm_pkg::INDEX_W-1:0]  idx_m;
  logic [AW-1:0]                idx_word;
  logic [OW-1:0]                idx_off;
  logic [AW-1:0]                start_addr, next_addr;
  logic [CW-1:0]                n_eff;

  logic [WORD_BITS-1:0]         rd_data, cand, flip_mask, new_word;
  logic [OW-1:0]                sel;
  logic                         is_test, is_search, want, from_top;
  logic                         bit_cur, hit, modify, last_word;
  logic [bsm_pkg::STATUS_W-1:0] ev_status;
  logic [bsm_pkg::POS_W-1:0]    ev_pos;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]         ram_wdata;

  // bit index to word and offset
  always_comb begin
    idx_m    = in_bit_index;
    idx_word = '0;
    idx_off  = '0;
    for (int k = 1; k < 4; k++) begin
      if (int'(in_bit_index) >= k * BITMAP_BITS) begin
        idx_m = bsm_pkg::INDEX_W'(int'(in_bit_index) - k * BITMAP_BITS);
      end
    end
    for (int q = 0; q < DEC_WORDS; q++) begin
      if (int'(idx_m) >= q * WORD_BITS) begin
        idx_word = AW'(q);
        idx_off  = OW'(int'(idx_m) - q * WORD_BITS);
      end
    end
  end

  assign n_eff = (CW'(bits_in_use_r) > CW'(BITMAP_BITS)) ? CW'(BITMAP_BITS)
                                                         : CW'(bits_in_use_r);

  assign start_addr = op_test(in_opcode) ? idx_word
                    : (op_top(in_opcode) ? AW'(NWORDS - 1) : '0);
  assign next_addr  = from_top ? AW'(addr_r - 1'b1) : AW'(addr_r + 1'b1);

  // word evaluation
  always_comb begin
    is_test   = op_test(op_r);
    from_top  = op_top(op_r);
    is_search = op_r == bsm_pkg::OP_LAST_SET_CLR || op_r == bsm_pkg::OP_LAST_ZERO_SET ||
                op_r == bsm_pkg::OP_FIRST_SET_CLR || op_r == bsm_pkg::OP_FIRST_ZERO_SET;
    want      = op_r == bsm_pkg::OP_LAST_SET_CLR || op_r == bsm_pkg::OP_FIRST_SET_CLR;
    for (int b = 0; b < WORD_BITS; b++) begin
      cand[b] = (rd_data[b] == want) && ((base_r + CW'(b)) < n_eff);
    end
    sel = '0;
    if (from_top) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        if (cand[b]) sel = OW'(b);
      end
    end else begin
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
        if (cand[b]) sel = OW'(b);
      end
    end
    hit       = |cand;
    bit_cur   = rd_data[off_r];
    modify    = is_test ? (bit_cur != (op_r == bsm_pkg::OP_TEST_SET)) : (is_search && hit);
    flip_mask = WORD_BITS'(1) << (is_test ? off_r : sel);
    new_word  = rd_data ^ flip_mask;
    last_word = from_top ? (addr_r == '0) : (addr_r == AW'(NWORDS - 1));
    if (is_test) begin
      ev_status = modify ? bsm_pkg::STAT_DONE : bsm_pkg::STAT_DENIED;
    end else if (is_search && hit) begin
      ev_status = bsm_pkg::STAT_DONE;
    end else begin
      ev_status = bsm_pkg::STAT_NODATA;
    end
    ev_pos = (is_search && hit) ? bsm_pkg::POS_W'(base_r + CW'(sel)) : '0;
  end

  assign ram_we    = cmd.clear || (cmd.finish && modify);
  assign ram_waddr = cmd.clear ? clr_cnt_r : addr_r;
  assign ram_wdata = cmd.clear ? '0 : new_word;
  assign ram_raddr = cmd.start ? start_addr : next_addr;

  bsm_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_comb begin
    bits_in_use_nxt  = cfg_wr_en ? cfg_wr_data : bits_in_use_r;
    op_nxt           = op_r;
    off_nxt          = off_r;
    addr_nxt         = addr_r;
    base_nxt         = base_r;
    clr_cnt_nxt      = cmd.clear ? AW'(clr_cnt_r + 1'b1) : clr_cnt_r;
    res_status_nxt   = res_status_r;
    res_pos_nxt      = res_pos_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_position_nxt = out_position_r;
    if (cmd.start) begin
      op_nxt   = in_opcode;
      off_nxt  = idx_off;
      addr_nxt = start_addr;
      base_nxt = op_top(in_opcode) ? CW'(TOP_BASE) : '0;
    end
    if (cmd.scan_next) begin
      addr_nxt = next_addr;
      base_nxt = from_top ? CW'(base_r - CW'(WORD_BITS)) : CW'(base_r + CW'(WORD_BITS));
    end
    if (cmd.finish) begin
      res_status_nxt = ev_status;
      res_pos_nxt    = ev_pos;
    end
    if (cmd.out_load_eval) begin
      out_valid_nxt    = 1'b1;
      out_status_nxt   = ev_status;
      out_position_nxt = ev_pos;
    end else if (cmd.out_load_post) begin
      out_valid_nxt    = 1'b1;
      out_status_nxt   = res_status_r;
      out_position_nxt = res_pos_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_in_use_r <= bsm_pkg::BITS_IN_USE_RST;
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      bits_in_use_r <= bits_in_use_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    off_r          <= off_nxt;
    addr_r         <= addr_nxt;
    base_r         <= base_nxt;
    res_status_r   <= res_status_nxt;
    res_pos_r      <= res_pos_nxt;
    out_status_r   <= out_status_nxt;
    out_position_r <= out_position_nxt;
  end

  assign stat.clear_last = clr_cnt_r == AW'(NWORDS - 1);
  assign stat.item_done  = !is_search || hit || last_word;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;

  a_load_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load_eval || cmd.out_load_post) |-> (!out_valid_r || out_ready))
    else $error("result loaded over an unread beat");

  a_pos_zero_unless_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != bsm_pkg::STAT_DONE) |-> out_position_r == '0)
    else $error("nonzero position on a failed beat");

  a_no_write_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !ram_we)
    else $error("bitmap written while a request is taken");

  a_no_scan_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_next |-> (is_search && !last_word))
    else $error("scan stepped past the last word");

endmodule

// ===== rtl/core/bitmap_search_and_mark.sv =====
// bitmap allocator: keeps a bitmap, cleared at reset, and serves one request per beat
// input beat: in_opcode and in_bit_index on in_valid/in_ready
//   test-set / test-clear flip the addressed bit or answer denied
//   the four searches find the lowest or highest set or clear bit among the
//   first bits_in_use bits, flip it and return its position, or answer no data
// result beat: out_status and out_position on out_valid/out_ready, one per request
// cfg_wr_en/cfg_wr_data write bits_in_use (reset 256); the user must write it only
//   while the block is idle, since the block itself does not enforce this
// a test request is evaluated in the state after acceptance; the block then returns
//   to idle and takes the next request once the result is loaded for output
// a search reads one bitmap word per cycle from the word memory, nearest end first,
//   and stops at the first hit or at the last word of the bitmap
// after reset a clearing pass writes zeros to every word, one word a cycle, and
//   in_ready stays low meanwhile
// the output register holds a finished result while the receiver stalls, and the next
//   request is still accepted; its result waits inside until the register drains
module bitmap_search_and_mark #(
  parameter int BITMAP_BITS = bsm_pkg::BITMAP_BITS_DEF,
  parameter int WORD_BITS   = bsm_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bsm_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bsm_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [bsm_pkg::INDEX_W-1:0]   in_bit_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bsm_pkg::STATUS_W-1:0]  out_status,
  output logic [bsm_pkg::POS_W-1:0]     out_position
);

  bsm_pkg::ctrl_cmd_t cmd;
  bsm_pkg::dp_stat_t  stat;

  bsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsm_dp #(
    .BITMAP_BITS (BITMAP_BITS),
    .WORD_BITS   (WORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_opcode    (in_opcode),
    .in_bit_index (in_bit_index),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_position (out_position),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

// ===== tb/sv/tb_bitmap_search_and_mark.sv =====
module tb_bitmap_search_and_mark;
  timeunit 1ns;
  timeprecision 1ps;

  import bsm_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_UNUSED7 = 3'd7;
  localparam int NWORDS = BITMAP_BITS_DEF / WORD_BITS_DEF;
  localparam int ITEMS_PER_PHASE = 108;
  localparam int NUM_PHASES = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
  } answer_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [INDEX_W-1:0]  idx;
    logic                typed;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
  } dir_row_t;

  // with bits_in_use at its reset value of 256 and an empty bitmap
  localparam dir_row_t DIR_ROWS [20] = '{
    '{OP_FIRST_SET_CLR,  8'd0,   1'b1, STAT_NODATA, 8'd0},
    '{OP_LAST_SET_CLR,   8'd0,   1'b1, STAT_NODATA, 8'd0},
    '{OP_FIRST_ZERO_SET, 8'd0,   1'b1, STAT_DONE,   8'd0},
    '{OP_LAST_ZERO_SET,  8'd0,   1'b1, STAT_DONE,   8'd255},
    '{OP_TEST_SET,       8'd0,   1'b1, STAT_DENIED, 8'd0},
    '{OP_TEST_SET,       8'd255, 1'b1, STAT_DENIED, 8'd0},
    '{OP_TEST_CLR,       8'd255, 1'b1, STAT_DONE,   8'd0},
    '{OP_TEST_CLR,       8'd255, 1'b1, STAT_DENIED, 8'd0},
    '{OP_UNUSED6,        8'hAA,  1'b1, STAT_NODATA, 8'd0},
    '{OP_UNUSED7,        8'h55,  1'b1, STAT_NODATA, 8'd0},
    '{OP_TEST_SET,       8'd63,  1'b0, STAT_DONE,   8'd0},
    '{OP_TEST_SET,       8'd64,  1'b0, STAT_DONE,   8'd0},
    '{OP_TEST_SET,       8'd191, 1'b0, STAT_DONE,   8'd0},
    '{OP_LAST_SET_CLR,   8'd0,   1'b0, STAT_DONE,   8'd0},
    '{OP_FIRST_SET_CLR,  8'hFF,  1'b0, STAT_DONE,   8'd0},
    '{OP_FIRST_ZERO_SET, 8'd0,   1'b0, STAT_DONE,   8'd0},
    '{OP_TEST_CLR,       8'd0,   1'b0, STAT_DONE,   8'd0},
    '{OP_LAST_ZERO_SET,  8'd0,   1'b0, STAT_DONE,   8'd0},
    '{OP_TEST_CLR,       8'd128, 1'b0, STAT_DONE,   8'd0},
    '{OP_FIRST_SET_CLR,  8'd0,   1'b0, STAT_DONE,   8'd0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OPCODE_W-1:0] in_opcode = '0;
  logic [INDEX_W-1:0]  in_bit_index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [POS_W-1:0]    out_position;

  logic [WORD_BITS_DEF-1:0] bitmap_copy [NWORDS];
  logic [CFG_W-1:0]         search_len;
  answer_t                  pending_answers [$];
  int                       fail_count = 0;
  bit                       quiet_run = 1'b0;

  bitmap_search_and_mark u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_bit_index (in_bit_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_position (out_position)
  );

  always #6 clk = ~clk;

  function automatic answer_t predict_answer(input logic [OPCODE_W-1:0] op,
                                             input logic [INDEX_W-1:0] idx);
    answer_t a;
    int n;
    int p;
    logic [7:0] pb;
    logic want;
    logic from_top;
    logic target;
    a.status = STAT_NODATA;
    a.position = '0;
    n = (search_len > 9'd256) ? 256 : int'(search_len);
    if (op == OP_TEST_SET || op == OP_TEST_CLR) begin
      target = (op == OP_TEST_SET);
      if (bitmap_copy[idx[7:6]][idx[5:0]] == target) begin
        a.status = STAT_DENIED;
      end else begin
        bitmap_copy[idx[7:6]][idx[5:0]] = target;
        a.status = STAT_DONE;
      end
    end else if (op == OP_LAST_SET_CLR || op == OP_LAST_ZERO_SET ||
                 op == OP_FIRST_SET_CLR || op == OP_FIRST_ZERO_SET) begin
      want = (op == OP_LAST_SET_CLR || op == OP_FIRST_SET_CLR);
      from_top = (op == OP_LAST_SET_CLR || op == OP_LAST_ZERO_SET);
      for (int k = 0; k < n; k++) begin
        p = from_top ? (n - 1 - k) : k;
        pb = p[7:0];
        if (bitmap_copy[pb[7:6]][pb[5:0]] == want) begin
          bitmap_copy[pb[7:6]][pb[5:0]] = ~want;
          a.status = STAT_DONE;
          a.position = pb;
          break;
        end
      end
    end
    return a;
  endfunction

  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                              input bit typed, input answer_t typed_answer);
    answer_t a;
    if (!quiet_run && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 26);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_bit_index <= idx;
    do @(posedge clk); while (!in_ready);
    a = predict_answer(op, idx);
    pending_answers.push_back(typed ? typed_answer : a);
  endtask

  task automatic drain_answers();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_search_len(input logic [CFG_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    search_len = v;
  endtask

  always @(posedge clk) begin
    out_ready <= quiet_run || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    answer_t exp_a;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("result beat with nothing expected: status %0d position %0d",
               out_status, out_position);
        fail_count++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (out_status !== exp_a.status) begin
          $error("status mismatch: expected %0d actual %0d", exp_a.status, out_status);
          fail_count++;
        end
        if (out_position !== exp_a.position) begin
          $error("position mismatch: expected %0d actual %0d", exp_a.position, out_position);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] len_plan [NUM_PHASES];
    logic [OPCODE_W-1:0] op;
    logic [INDEX_W-1:0] idx;
    int bias;
    int r;
    bit set_kind;
    answer_t typed_a;
    len_plan = '{9'd0, 9'd1, 9'd511, 9'd64, 9'd65, 9'd300, 9'd127, 9'd256, 9'd0, 9'd0};
    len_plan[8] = CFG_W'($urandom_range(256, 1));
    len_plan[9] = CFG_W'($urandom_range(511, 0));
    for (int w = 0; w < NWORDS; w++) bitmap_copy[w] = '0;
    search_len = BITS_IN_USE_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) begin
      typed_a.status = DIR_ROWS[i].status;
      typed_a.position = DIR_ROWS[i].position;
      send_request(DIR_ROWS[i].op, DIR_ROWS[i].idx, DIR_ROWS[i].typed, typed_a);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_answers();
      write_search_len(len_plan[ph]);
      quiet_run = (ph == 4);
      bias = (ph % 3 == 0) ? 80 : ((ph % 3 == 1) ? 20 : 50);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(99);
        if (r < 3) begin
          op = (r % 2 == 0) ? OP_UNUSED6 : OP_UNUSED7;
        end else begin
          set_kind = ($urandom_range(99) < bias);
          case ($urandom_range(2))
            0: op = set_kind ? OP_TEST_SET : OP_TEST_CLR;
            1: op = set_kind ? OP_FIRST_ZERO_SET : OP_FIRST_SET_CLR;
            default: op = set_kind ? OP_LAST_ZERO_SET : OP_LAST_SET_CLR;
          endcase
        end
        if (search_len != 0 && $urandom_range(1) == 0) begin
          idx = INDEX_W'($urandom_range((search_len > 9'd256 ? 256 : int'(search_len)) - 1));
        end else begin
          idx = INDEX_W'($urandom_range(255));
        end
        // sender holds off until every outstanding beat has come back
        if (ph == 2 && i == ITEMS_PER_PHASE / 2) drain_answers();
        typed_a = '0;
        send_request(op, idx, 1'b0, typed_a);
      end
    end
    quiet_run = 1'b0;

    drain_answers();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
